### rtl/text_console_cursor_engine_macros.svh
// Assertion macros for the text console cursor engine.
// Used by the top level only; no other dependencies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TCCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// Next-cycle implication, disabled while in reset.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

### rtl/tcce_pkg.sv
// Shared types, constants and address helpers for the text console engine.
// No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int LIN_W      = 12;   // row * COLUMNS + col for the widest screen

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] code;
    } t_cell;

    typedef struct packed {
        logic       we;
        t_addr      addr;
        t_cell      data;
    } t_cell_wr;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
        logic [3:0] fg_color;
        logic [3:0] bg_color;
        logic [6:0] col_x;
        logic [4:0] row_y;
    } t_req;

    typedef struct packed {
        logic [4:0]  cur_row;
        logic [6:0]  cur_col;
        logic [10:0] cursor_pos;
        logic        scrolled;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        error;
    } t_rsp;

    // Operation codes
    localparam logic [2:0] FN_PUT   = 3'd0;
    localparam logic [2:0] FN_CLEAR = 3'd1;
    localparam logic [2:0] FN_SETC  = 3'd2;
    localparam logic [2:0] FN_WRITE = 3'd3;
    localparam logic [2:0] FN_READ  = 3'd4;

    // Character codes
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [7:0] TAB_STEP   = 8'd8;
    localparam logic [7:0] TAB_MASK   = 8'hF8;

    localparam t_addr LAST_CELL   = t_addr'(CELL_COUNT - 1);
    localparam t_addr SCROLL_LAST = t_addr'(CELL_COUNT - COLUMNS - 1);
    localparam t_addr BOTTOM_BASE = t_addr'((ROWS - 1) * COLUMNS);
    localparam t_addr ROW_STRIDE  = t_addr'(COLUMNS);

    function automatic logic [LIN_W-1:0] lin_pos(input logic [4:0] row, input logic [6:0] col);
        return LIN_W'(row) * LIN_W'(COLUMNS) + LIN_W'(col);
    endfunction

    function automatic t_addr cell_addr(input logic [4:0] row, input logic [6:0] col);
        logic [LIN_W-1:0] lin;
        lin = lin_pos(row, col);
        return t_addr'(lin);
    endfunction

endpackage

### rtl/tcce_cells.sv
// Cell store: one write port, one read port with registered read data.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_cells (
    input  logic              i_clk,
    input  tcce_pkg::t_cell_wr i_wr,
    input  tcce_pkg::t_addr   i_raddr,
    output tcce_pkg::t_cell   o_rdata
);
    import tcce_pkg::*;

    t_cell r_mem [CELL_COUNT];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/text_console_cursor_engine.sv
// Text console engine top: request decode, cursor, scroll/clear sweeps, result register.
// Depends on tcce_pkg, tcce_cells and text_console_cursor_engine_macros.svh.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------
//  request  | in        | i_in_valid / o_in_stall   | i_in  (t_req)
//  result   | out       | o_out_valid / i_out_stall | o_out (t_rsp)
//  config   | in        | i_cfg_we (no wait)        | i_cfg_wdata
//
// One request at a time. Put char, set cursor, write cell: accept, execute, result load
// (held while a previous result is stalled); read cell: one extra step for the cell store read latency.
// Scroll copies the store through its single read/write port pair, one cell a cycle,
// then blanks the bottom row. Clear blanks every cell.
// After reset a clearing pass fills the store; requests stall meanwhile.
// The next request is taken while the previous result still waits behind i_out_stall.
`timescale 1ns / 1ps
`include "text_console_cursor_engine_macros.svh"

module text_console_cursor_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tcce_pkg::t_req  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output tcce_pkg::t_rsp  o_out
);
    import tcce_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_SCROLL = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_FILL   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] r_state, n_state;
    t_addr      r_addr, n_addr;
    logic       r_wr_pend, n_wr_pend;
    t_addr      r_wr_addr, n_wr_addr;
    logic [4:0] r_row, n_row;
    logic [6:0] r_col, n_col;
    logic [7:0] r_color;
    logic       r_out_valid, n_out_valid;
    t_req       r_req, n_req;
    logic       r_scrolled, n_scrolled;
    logic       r_err, n_err;
    t_cell      r_cell, n_cell;
    t_rsp       r_out, n_out;

    t_cell_wr   ram_wr;
    t_addr      ram_raddr;
    t_cell      ram_rdata;

    // request decode
    logic             in_range;
    t_addr            req_at;
    t_addr            cur_idx;
    logic [7:0]       pc_col;
    logic [5:0]       pc_row;
    logic [LIN_W-1:0] out_lin;

    tcce_cells u_cells (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_range = ({1'b0, r_req.col_x} < 8'(COLUMNS)) && ({1'b0, r_req.row_y} < 6'(ROWS));
    assign req_at   = cell_addr(r_req.row_y, r_req.col_x);
    assign cur_idx  = cell_addr(r_row, r_col);
    assign out_lin  = lin_pos(r_row, r_col);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_req       = r_req;
        n_scrolled  = r_scrolled;
        n_err       = r_err;
        n_cell      = r_cell;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_wr      = '{we: 1'b0, addr: r_addr, data: '{attr: r_color, code: CH_SPACE}};
        ram_raddr   = r_addr + ROW_STRIDE;
        pc_col      = {1'b0, r_col};
        pc_row      = {1'b0, r_row};

        unique case (r_state)
            S_INIT: begin
                ram_wr = '{we: 1'b1, addr: r_addr, data: '{attr: RESET_ATTR, code: CH_SPACE}};
                if (r_addr == LAST_CELL) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + t_addr'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req      = i_in;
                    n_scrolled = 1'b0;
                    n_err      = 1'b0;
                    n_cell     = '0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_req.func)
                    FN_PUT: begin
                        unique case (r_req.char_code)
                            CH_NEWLINE: begin
                                pc_col = '0;
                                pc_row = {1'b0, r_row} + 6'd1;
                            end
                            CH_RETURN: begin
                                pc_col = '0;
                            end
                            CH_TAB: begin
                                pc_col = ({1'b0, r_col} + TAB_STEP) & TAB_MASK;
                            end
                            CH_BACKSPACE: begin
                                // at column 0 nothing changes
                                if (r_col != '0) begin
                                    pc_col = {1'b0, r_col} - 8'd1;
                                    ram_wr = '{we: 1'b1,
                                               addr: cell_addr(r_row, r_col - 7'd1),
                                               data: '{attr: r_color, code: CH_SPACE}};
                                end
                            end
                            default: begin
                                pc_col = {1'b0, r_col} + 8'd1;
                                ram_wr = '{we: 1'b1, addr: cur_idx,
                                           data: '{attr: r_color, code: r_req.char_code}};
                            end
                        endcase
                        if (pc_col >= 8'(COLUMNS)) begin
                            pc_col = '0;
                            pc_row = pc_row + 6'd1;
                        end
                        n_col = pc_col[6:0];
                        if (pc_row >= 6'(ROWS)) begin
                            n_row      = 5'(ROWS - 1);
                            n_scrolled = 1'b1;
                            n_addr     = '0;
                            n_wr_pend  = 1'b0;
                            n_state    = S_SCROLL;
                        end else begin
                            n_row = pc_row[4:0];
                        end
                    end
                    FN_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_addr  = '0;
                        n_state = S_FILL;
                    end
                    FN_SETC: begin
                        if (in_range) begin
                            n_row = r_req.row_y;
                            n_col = r_req.col_x;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    FN_WRITE: begin
                        if (in_range) begin
                            ram_wr = '{we: 1'b1, addr: req_at,
                                       data: '{attr: {r_req.bg_color, r_req.fg_color},
                                               code: r_req.char_code}};
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    FN_READ: begin
                        ram_raddr = req_at;
                        if (in_range) begin
                            n_state = S_RDWAIT;
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDWAIT: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_SCROLL: begin
                // read one row ahead, write back the cell read last cycle
                ram_wr    = '{we: r_wr_pend, addr: r_wr_addr, data: ram_rdata};
                n_wr_pend = 1'b1;
                n_wr_addr = r_addr;
                if (r_addr == SCROLL_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + t_addr'(1);
                end
            end
            S_DRAIN: begin
                ram_wr    = '{we: 1'b1, addr: r_wr_addr, data: ram_rdata};
                n_wr_pend = 1'b0;
                n_addr    = BOTTOM_BASE;
                n_state   = S_FILL;
            end
            S_FILL: begin
                ram_wr = '{we: 1'b1, addr: r_addr, data: '{attr: r_color, code: CH_SPACE}};
                if (r_addr == LAST_CELL) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = r_addr + t_addr'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out = '{cur_row:    r_row,
                              cur_col:    r_col,
                              cursor_pos: out_lin[10:0],
                              scrolled:   r_scrolled,
                              cell_char:  r_cell.code,
                              cell_attr:  r_cell.attr,
                              error:      r_err};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_wr_pend   <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_color     <= RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_wr_pend   <= n_wr_pend;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_req      <= n_req;
        r_scrolled <= n_scrolled;
        r_err      <= n_err;
        r_cell     <= n_cell;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TCCE_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_EXEC)
    `TCCE_ASSERT_IMPL(a_cursor_in_screen, i_clk, i_rst_n, r_state == S_IDLE, ({1'b0, r_col} < 8'(COLUMNS)) && ({1'b0, r_row} < 6'(ROWS)))
    `TCCE_ASSERT_IMPL(a_scroll_write_behind, i_clk, i_rst_n, (r_state == S_SCROLL) && r_wr_pend, r_wr_addr < ram_raddr)

endmodule
